### design/cem_pkg.sv
// ----------------------------------------------------------------------------
// cem_pkg
// Shared constants, types and state encoding for the coalescing extent map.
// ----------------------------------------------------------------------------
`default_nettype none

package cem_pkg;

  localparam int MAX_EXTENTS = 16;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int START_W     = 32;
  localparam int LEN_W       = 33;
  localparam int ENT_W       = START_W + LEN_W;
  localparam int CNT_OUT_W   = 5;
  localparam int PADDR_W     = 3;

  localparam logic       FUNC_LOOKUP     = 1'b1;
  localparam logic       REG_OBJ_SIZE    = 1'b0;
  localparam logic [31:0] OBJ_SIZE_RST   = 32'd4194304;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_DEC,
    ST_MV_RD,
    ST_MV_WR,
    ST_WR_HEAD,
    ST_FIN
  } eng_state_t;

  typedef struct packed {
    logic                covered;
    logic                fully_cached;
    logic [LEN_W-1:0]    total_bytes;
    logic [CNT_W-1:0]    extent_count;
    logic                table_full;
    logic [31:0]         update_count;
  } res_t;

endpackage

`default_nettype wire

### design/cem_ram.sv
// ----------------------------------------------------------------------------
// cem_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cem_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 65
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/cem_engine.sv
// ----------------------------------------------------------------------------
// cem_engine
// Sequencer that scans, merges and compacts the extent table held in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module cem_engine import cem_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        req_valid,
  input  wire logic        req_func,
  input  wire logic [31:0] req_offset,
  input  wire logic [31:0] req_length,
  input  wire logic [31:0] obj_size,
  output logic             busy,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res
);

  eng_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LEN_W-1:0]   total_r, total_nxt;
  logic               fc_r, fc_nxt;
  logic [31:0]        upd_r, upd_nxt;

  logic               op_r, op_nxt;
  logic [31:0]        lo_r, lo_nxt;
  logic [LEN_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]   stop_r, stop_nxt;
  logic               found_r, found_nxt;
  logic [31:0]        newlo_r, newlo_nxt;
  logic [LEN_W-1:0]   newhi_r, newhi_nxt;
  logic [LEN_W-1:0]   sub_r, sub_nxt;
  logic               cov_r, cov_nxt;
  logic               full_r, full_nxt;
  logic               up_r, up_nxt;
  logic [CNT_W-1:0]   src_r, src_nxt;
  logic [CNT_W-1:0]   dst_r, dst_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;

  // Moves read an entry before any write to it, so no forwarding.
  cem_ram #(
    .DEPTH (MAX_EXTENTS),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [31:0]      ent_s;
  logic [LEN_W-1:0] ent_l;
  logic [LEN_W-1:0] ent_e;
  logic [CNT_W-1:0] span;
  logic [LEN_W-1:0] newlen;
  logic [LEN_W-1:0] inslen;
  logic             brk;

  assign ent_s  = ram_rdata[ENT_W-1:LEN_W];
  assign ent_l  = ram_rdata[LEN_W-1:0];
  assign ent_e  = {1'b0, ent_s} + ent_l;
  assign span   = CNT_W'(stop_r - first_r - 1'b1);
  assign newlen = newhi_r - {1'b0, newlo_r};
  assign inslen = hi_r - {1'b0, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      total_r <= '0;
      fc_r    <= 1'b0;
      upd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      fc_r    <= fc_nxt;
      upd_r   <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    stop_r  <= stop_nxt;
    found_r <= found_nxt;
    newlo_r <= newlo_nxt;
    newhi_r <= newhi_nxt;
    sub_r   <= sub_nxt;
    cov_r   <= cov_nxt;
    full_r  <= full_nxt;
    up_r    <= up_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    end_r   <= end_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    total_nxt = total_r;
    fc_nxt    = fc_r;
    upd_nxt   = upd_r;
    op_nxt    = op_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    stop_nxt  = stop_r;
    found_nxt = found_r;
    newlo_nxt = newlo_r;
    newhi_nxt = newhi_r;
    sub_nxt   = sub_r;
    cov_nxt   = cov_r;
    full_nxt  = full_r;
    up_nxt    = up_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    end_nxt   = end_r;
    ram_we    = 1'b0;
    ram_waddr = first_r[IDX_W-1:0];
    ram_wdata = {newlo_r, newlen};
    ram_raddr = idx_r[IDX_W-1:0];
    res_valid = 1'b0;
    brk       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          op_nxt    = req_func;
          lo_nxt    = req_offset;
          hi_nxt    = {1'b0, req_offset} + {1'b0, req_length};
          idx_nxt   = '0;
          first_nxt = '0;
          found_nxt = 1'b0;
          cov_nxt   = 1'b0;
          full_nxt  = 1'b0;
          if (req_func != FUNC_LOOKUP) begin
            upd_nxt = upd_r + 32'd1;
          end
          if (count_r != '0) begin
            state_nxt = ST_RD;
          end else if (req_func == FUNC_LOOKUP) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_DEC;
          end
        end
      end

      ST_RD: begin
        ram_raddr = idx_r[IDX_W-1:0];
        state_nxt = ST_EV;
      end

      ST_EV: begin
        if (op_r == FUNC_LOOKUP) begin
          if ({1'b0, ent_s} <= {1'b0, lo_r} && ent_e >= hi_r) begin
            cov_nxt = 1'b1;
          end
        end else if (!found_r) begin
          if (ent_e < {1'b0, lo_r}) begin
            first_nxt = CNT_W'(idx_r + 1'b1);
          end else if ({1'b0, ent_s} <= hi_r) begin
            found_nxt = 1'b1;
            stop_nxt  = CNT_W'(idx_r + 1'b1);
            newlo_nxt = (ent_s < lo_r) ? ent_s : lo_r;
            newhi_nxt = (ent_e > hi_r) ? ent_e : hi_r;
            sub_nxt   = ent_l;
          end else begin
            brk = 1'b1;
          end
        end else begin
          if ({1'b0, ent_s} <= hi_r) begin
            stop_nxt  = CNT_W'(idx_r + 1'b1);
            newhi_nxt = (ent_e > hi_r) ? ent_e : hi_r;
            sub_nxt   = sub_r + ent_l;
          end else begin
            brk = 1'b1;
          end
        end
        idx_nxt = CNT_W'(idx_r + 1'b1);
        if (CNT_W'(idx_r + 1'b1) == count_r || brk) begin
          state_nxt = (op_r == FUNC_LOOKUP) ? ST_FIN : ST_DEC;
        end else begin
          state_nxt = ST_RD;
        end
      end

      ST_DEC: begin
        if (found_r) begin
          // merged extent lands in the first spanned slot
          ram_we    = 1'b1;
          ram_waddr = first_r[IDX_W-1:0];
          ram_wdata = {newlo_r, newlen};
          total_nxt = total_r - sub_r + newlen;
          count_nxt = count_r - span;
          if (count_nxt == CNT_W'(1) && newlo_r == '0 && newlen == {1'b0, obj_size}) begin
            fc_nxt = 1'b1;
          end
          if (stop_r == count_r) begin
            state_nxt = ST_FIN;
          end else begin
            up_nxt    = 1'b0;
            src_nxt   = stop_r;
            dst_nxt   = CNT_W'(first_r + 1'b1);
            end_nxt   = count_r;
            state_nxt = ST_MV_RD;
          end
        end else if (hi_r == {1'b0, lo_r}) begin
          state_nxt = ST_FIN;
        end else if (count_r == CNT_W'(MAX_EXTENTS)) begin
          full_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          total_nxt = total_r + inslen;
          count_nxt = CNT_W'(count_r + 1'b1);
          if (count_r == '0 && lo_r == '0 && inslen == {1'b0, obj_size}) begin
            fc_nxt = 1'b1;
          end
          if (first_r == count_r) begin
            state_nxt = ST_WR_HEAD;
          end else begin
            up_nxt    = 1'b1;
            src_nxt   = CNT_W'(count_r - 1'b1);
            dst_nxt   = count_r;
            state_nxt = ST_MV_RD;
          end
        end
      end

      ST_MV_RD: begin
        ram_raddr = src_r[IDX_W-1:0];
        state_nxt = ST_MV_WR;
      end

      ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (up_r) begin
          src_nxt   = CNT_W'(src_r - 1'b1);
          dst_nxt   = CNT_W'(dst_r - 1'b1);
          state_nxt = (CNT_W'(dst_r - 1'b1) == first_r) ? ST_WR_HEAD : ST_MV_RD;
        end else begin
          src_nxt   = CNT_W'(src_r + 1'b1);
          dst_nxt   = CNT_W'(dst_r + 1'b1);
          state_nxt = (CNT_W'(src_r + 1'b1) == end_r) ? ST_FIN : ST_MV_RD;
        end
      end

      ST_WR_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = first_r[IDX_W-1:0];
        ram_wdata = {lo_r, inslen};
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign res.covered      = cov_r;
  assign res.fully_cached = fc_r;
  assign res.total_bytes  = total_r;
  assign res.extent_count = count_r;
  assign res.table_full   = full_r;
  assign res.update_count = upd_r;

endmodule

`default_nettype wire

### design/coalescing_extent_map.sv
// ----------------------------------------------------------------------------
// coalescing_extent_map
// Sorted table of disjoint byte extents with merge-on-insert and coverage test.
// ----------------------------------------------------------------------------
// Each request walks the extent table in RAM, a RAM read and then an
// evaluate step per stored extent visited. A lookup visits every stored
// extent. An update scans up to the first extent past the new range, then
// reads and writes back each extent moved when the table is compacted after a
// merge or opened up for an insert, after a decision step; an insert ends
// with a write of the new entry. The single RAM read port serialises reads.
// The next request is taken while the previous result waits in the output
// register. Extent count, total bytes and the table fill level are held in
// registers, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module coalescing_extent_map import cem_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic [31:0]        in_offset,
  input  wire logic [31:0]        in_length,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_covered,
  output logic                    out_fully_cached,
  output logic [LEN_W-1:0]        out_total_bytes,
  output logic [CNT_OUT_W-1:0]    out_extent_count,
  output logic                    out_table_full,
  output logic [31:0]             out_update_count,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic [31:0] obj_size_r;
  logic        busy;
  logic        res_valid;
  logic        res_ready;
  res_t        res;

  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_OBJ_SIZE) ? obj_size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_size_r <= OBJ_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_OBJ_SIZE) begin
      obj_size_r <= cfg_pwdata;
    end
  end

  cem_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_func    (in_func),
    .req_offset  (in_offset),
    .req_length  (in_length),
    .obj_size    (obj_size_r),
    .busy        (busy),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign in_stall  = busy;
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_covered      = out_res_r.covered;
  assign out_fully_cached = out_res_r.fully_cached;
  assign out_total_bytes  = out_res_r.total_bytes;
  assign out_extent_count = CNT_OUT_W'(out_res_r.extent_count);
  assign out_table_full   = out_res_r.table_full;
  assign out_update_count = out_res_r.update_count;

endmodule

`default_nettype wire

### design/cem_checker.sv
// ----------------------------------------------------------------------------
// cem_port_checks
// Port-level checks for the coalescing extent map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cem_port_checks import cem_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_covered,
  input wire logic                 out_fully_cached,
  input wire logic [LEN_W-1:0]     out_total_bytes,
  input wire logic [CNT_OUT_W-1:0] out_extent_count,
  input wire logic                 out_table_full,
  input wire logic [31:0]          out_update_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_bytes)
      && $stable(out_update_count) && $stable(out_extent_count))
    else $error("stalled result changed");

  // an accepted request keeps the block busy in the cycle after it is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without busy");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      !out_covered && out_extent_count == CNT_OUT_W'(MAX_EXTENTS))
    else $error("table_full with free slots or on lookup");

  a_cover_needs_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> out_extent_count != '0)
    else $error("covered with empty table");

endmodule

bind coalescing_extent_map cem_port_checks u_cem_port_checks (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_covered      (out_covered),
  .out_fully_cached (out_fully_cached),
  .out_total_bytes  (out_total_bytes),
  .out_extent_count (out_extent_count),
  .out_table_full   (out_table_full),
  .out_update_count (out_update_count)
);

`default_nettype wire

### dv/cem_checker.sv
// ----------------------------------------------------------------------------
// cem_checker
// Watches the request and result channels of the extent map, predicts each
// result from its own copy of the extent table and compares field by field.
// ----------------------------------------------------------------------------
module cem_checker import cem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_func,
  input  logic [31:0]          in_offset,
  input  logic [31:0]          in_length,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_covered,
  input  logic                 out_fully_cached,
  input  logic [LEN_W-1:0]     out_total_bytes,
  input  logic [CNT_OUT_W-1:0] out_extent_count,
  input  logic                 out_table_full,
  input  logic [31:0]          out_update_count,
  input  logic [31:0]          obj_size,
  output int                   fail_count,
  output int                   pending,
  output int                   result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                 covered;
    logic                 fully_cached;
    logic [LEN_W-1:0]     total_bytes;
    logic [CNT_OUT_W-1:0] extent_count;
    logic                 table_full;
    logic [31:0]          update_count;
  } status_t;

  logic [31:0]      ext_lo  [MAX_EXTENTS];
  logic [LEN_W-1:0] ext_len [MAX_EXTENTS];
  int               n_ext;
  logic             full_flag;
  logic [31:0]      n_updates;
  status_t          expected_q[$];

  function automatic logic [LEN_W-1:0] ext_hi(int i);
    return {1'b0, ext_lo[i]} + ext_len[i];
  endfunction

  // Insert [lo, hi) with merge; returns 1 if dropped on a full table.
  function automatic logic merge_range(logic [LEN_W-1:0] lo, logic [LEN_W-1:0] hi);
    int first, stop, span;
    logic [LEN_W-1:0] nlo, nhi;
    first = 0;
    while (first < n_ext && ext_hi(first) < lo) first++;
    stop = first;
    while (stop < n_ext && {1'b0, ext_lo[stop]} <= hi) stop++;
    if (stop > first) begin
      nlo = (lo < {1'b0, ext_lo[first]}) ? lo : {1'b0, ext_lo[first]};
      nhi = (hi > ext_hi(stop - 1)) ? hi : ext_hi(stop - 1);
      ext_lo[first] = nlo[31:0];
      ext_len[first] = nhi - nlo;
      span = stop - first - 1;
      for (int k = first + 1; k + span < n_ext; k++) begin
        ext_lo[k] = ext_lo[k + span];
        ext_len[k] = ext_len[k + span];
      end
      n_ext -= span;
    end else if (hi == lo) begin
      return 1'b0;
    end else if (n_ext >= MAX_EXTENTS) begin
      return 1'b1;
    end else begin
      for (int k = n_ext; k > first; k--) begin
        ext_lo[k] = ext_lo[k - 1];
        ext_len[k] = ext_len[k - 1];
      end
      ext_lo[first] = lo[31:0];
      ext_len[first] = hi - lo;
      n_ext++;
    end
    if (n_ext == 1 && ext_lo[0] == 0 && ext_len[0] == {1'b0, obj_size})
      full_flag = 1'b1;
    return 1'b0;
  endfunction

  function automatic status_t predict_status(logic func, logic [31:0] off, logic [31:0] len);
    status_t s;
    logic [LEN_W-1:0] lo, hi;
    lo = {1'b0, off};
    hi = lo + {1'b0, len};
    s.covered = 1'b0;
    s.table_full = 1'b0;
    if (func == FUNC_LOOKUP) begin
      for (int i = 0; i < n_ext; i++)
        if ({1'b0, ext_lo[i]} <= lo && ext_hi(i) >= hi) s.covered = 1'b1;
    end else begin
      n_updates++;
      s.table_full = merge_range(lo, hi);
    end
    s.total_bytes = '0;
    for (int i = 0; i < n_ext; i++) s.total_bytes += ext_len[i];
    s.fully_cached = full_flag;
    s.extent_count = n_ext[CNT_OUT_W-1:0];
    s.update_count = n_updates;
    return s;
  endfunction

  task automatic report(string fld, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t: mismatch %s expected %0h actual %0h", $time, fld, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    status_t e;
    if (!rst_n) begin
      n_ext = 0;
      full_flag = 1'b0;
      n_updates = '0;
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_status(in_func, in_offset, in_length));
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual count %0d", $time,
                   out_extent_count);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (e.covered !== out_covered)
            report("covered", 64'(e.covered), 64'(out_covered));
          if (e.fully_cached !== out_fully_cached)
            report("fully_cached", 64'(e.fully_cached), 64'(out_fully_cached));
          if (e.total_bytes !== out_total_bytes)
            report("total_bytes", 64'(e.total_bytes), 64'(out_total_bytes));
          if (e.extent_count !== out_extent_count)
            report("extent_count", 64'(e.extent_count), 64'(out_extent_count));
          if (e.table_full !== out_table_full)
            report("table_full", 64'(e.table_full), 64'(out_table_full));
          if (e.update_count !== out_update_count)
            report("update_count", 64'(e.update_count), 64'(out_update_count));
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the coalescing extent map: directed edge cases, then random
// insert/lookup traffic over several object sizes with random idling on both
// channels and one long result hold-off. Checking lives in cem_checker.
// ----------------------------------------------------------------------------
module tb;
  import cem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_INSERT = ~FUNC_LOOKUP;
  localparam int   CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_func = 1'b0;
  logic [31:0] in_offset = '0, in_length = '0;
  logic in_stall, out_valid;
  logic out_stall = 1'b0;
  logic out_covered, out_fully_cached, out_table_full;
  logic [LEN_W-1:0] out_total_bytes;
  logic [CNT_OUT_W-1:0] out_extent_count;
  logic [31:0] out_update_count;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic [31:0] obj_size = OBJ_SIZE_RST;
  int fail_count, pending, result_count;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  coalescing_extent_map i_dut (.*);

  cem_checker i_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result-side stall: random bursts, a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet || !rst_n) out_stall <= 1'b0;
    else if ($urandom_range(0, 15) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
      out_stall <= 1'b0;
    end else out_stall <= 1'b0;
  end

  task automatic write_object_size(logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= PADDR_W'(4 * REG_OBJ_SIZE); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    obj_size = val;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Called at a falling edge; valid stays high between back-to-back requests.
  task automatic send(logic func, logic [31:0] off, logic [31:0] len);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1; in_func <= func; in_offset <= off; in_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4 * MAX_EXTENTS + 10) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly small ranges within the given span so extents merge often.
  task automatic random_phase(int count, logic [31:0] span);
    logic [31:0] off, len;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin off = $urandom(); len = $urandom(); end
        1: begin off = $urandom_range(0, span); len = 0; end
        default: begin
          off = $urandom_range(0, span);
          len = $urandom_range(1, span / 8 + 1);
        end
      endcase
      send($urandom_range(0, 2) == 0 ? FUNC_LOOKUP : FUNC_INSERT, off, len);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty lookup, zero length, touching merges, fill to full.
    send(FUNC_LOOKUP, 32'd0, 32'd0);
    send(FUNC_INSERT, 32'd100, 32'd0);
    send(FUNC_INSERT, 32'd100, 32'd50);
    send(FUNC_LOOKUP, 32'd150, 32'd0);
    send(FUNC_LOOKUP, 32'd100, 32'd50);
    send(FUNC_INSERT, 32'd150, 32'd10);
    send(FUNC_INSERT, 32'd10, 32'd5);
    send(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < MAX_EXTENTS; i++) send(FUNC_INSERT, 32'd1000 + 32'd20 * i, 32'd5);
    send(FUNC_INSERT, 32'd5000, 32'd5);
    send(FUNC_INSERT, 32'd0, 32'd6000);
    send(FUNC_INSERT, 32'd0, 32'd4194304);
    drain();

    // Long result hold-off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(40, 32'd1000);
    join
    drain();

    // Small object: fully-cached reached quickly.
    write_object_size(32'd64);
    random_phase(400, 32'd64);
    drain();
    write_object_size(32'hFFFF_FFFF);
    random_phase(300, 32'hFFFF_FFFF);
    drain();
    write_object_size(32'd0);
    random_phase(200, 32'd4096);
    drain();
    write_object_size(32'd2048);
    quiet = 1'b1;
    random_phase(330, 32'd2048);
    drain();

    $display("covered %0d results over object sizes 0, 64, 2048, 4 MiB and 4 GiB-1,",
             result_count);
    $display("with merges, table-full drops, zero-length ops and a long result hold-off");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
